// ===== hw/rtl/dsbf_pkg.sv =====
// Shared types, constants and helpers for the decimal string to base-100 converter.
// No dependencies.
`timescale 1ns / 1ps
package dsbf_pkg;

  localparam int MANTISSA_BYTES = 20;
  localparam int NDIG = 2 * MANTISSA_BYTES;
  localparam int CW   = $clog2(NDIG + 2);
  localparam int IW   = $clog2(MANTISSA_BYTES);
  localparam int EW   = 18;
  localparam int DPW  = 5;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_UE    = 8'h45;
  localparam logic [7:0] CH_LE    = 8'h65;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [14:0] EXP_GROW_MAX = 15'd3276;
  localparam logic [14:0] EXP_SAT      = 15'd32767;
  localparam logic signed [15:0] PT_MAX = 16'sd32767;
  localparam logic signed [15:0] PT_MIN = -16'sd32767;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_INVALID  = 2'd1;
  localparam logic [1:0] STAT_OVERFLOW = 2'd2;

  typedef enum logic [3:0] {
    PH_LEAD, PH_AFTERSIGN, PH_DOT1, PH_FZERO, PH_FRAC, PH_LZERO,
    PH_INT, PH_EXP1, PH_EXP2, PH_EXPD, PH_TRAIL
  } ph_t;

  typedef enum logic [2:0] {
    ST_PARSE, ST_LOAD, ST_SHIFT, ST_ROUND, ST_EXPCHK, ST_EMIT, ST_FAIL
  } st_t;

  // Quotient by 10 for values below 128, by reciprocal multiply.
  function automatic logic [3:0] div10(input logic [6:0] v);
    logic [17:0] p;
    p = 18'(v) * 18'd205;
    return 4'(p >> 11);
  endfunction

endpackage

// ===== hw/rtl/dsbf_if.sv =====
// Valid/ready channel interfaces for the character input and digit output.
// No dependencies.
`timescale 1ns / 1ps
interface dsbf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       is_last;
  logic       is_empty;
  modport source (output valid, ch, is_last, is_empty, input ready);
  modport sink   (input valid, ch, is_last, is_empty, output ready);
endinterface

interface dsbf_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       negative;
  logic [6:0] biased_exponent;
  logic [4:0] digit_pos;
  logic [6:0] digit_value;
  logic       last_digit;
  modport source (output valid, status, negative, biased_exponent, digit_pos,
                  digit_value, last_digit, input ready);
  modport sink   (input valid, status, negative, biased_exponent, digit_pos,
                  digit_value, last_digit, output ready);
endinterface

// ===== hw/rtl/decimal_string_to_base100_float.sv =====
// Top level: streaming decimal text parser and base-100 float normalizer.
// Depends on dsbf_pkg and the channel interfaces in dsbf_if.sv.
`timescale 1ns / 1ps
// Characters enter one beat per cycle while the string is parsed; leading
// spaces, a sign, digits with one point, an exponent and trailing spaces are
// taken, and up to 2*MANTISSA_BYTES significant digits are held in pairs in a
// register file. The beat with is_last closes the string and drops ready: a
// load state builds the decimal exponent, then, if the exponent is odd, a
// rotation pass shifts the mantissa one decimal digit through a
// divide-by-ten unit, then, if rounding is due, a carry pass runs the
// same rotation in the other direction, then a check state tests the
// range. Results follow as MANTISSA_BYTES beats (or one beat on failure),
// each held until taken. The mantissa store has no reset: entries past
// the digit count are masked to zero at load.
module decimal_string_to_base100_float (
  input  logic clk,
  input  logic rst_n,
  dsbf_in_if.sink    in_bus,
  dsbf_out_if.source out_bus
);
  import dsbf_pkg::*;

  st_t                  state_r, state_nxt;
  ph_t                  phase_r, phase_nxt;
  logic [6:0]           m_r [MANTISSA_BYTES];
  logic [6:0]           m_nxt [MANTISSA_BYTES];
  logic [6:0]           tens_r, tens_nxt;
  logic [CW-1:0]        dcnt_r, dcnt_nxt;
  logic signed [15:0]   pofs_r, pofs_nxt;
  logic [14:0]          eacc_r, eacc_nxt;
  logic                 eneg_r, eneg_nxt;
  logic                 sign_r, sign_nxt;
  logic                 rnd_r, rnd_nxt;
  logic                 err_r, err_nxt;
  logic signed [EW-1:0] e_r, e_nxt;
  logic [3:0]           low_r, low_nxt;
  logic                 carry_r, carry_nxt;
  logic [IW-1:0]        idx_r, idx_nxt;
  logic [1:0]           status_r, status_nxt;
  logic                 neg_r, neg_nxt;
  logic [6:0]           bexp_r, bexp_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_PARSE;
      phase_r <= PH_LEAD;
      dcnt_r  <= '0;
      pofs_r  <= '0;
      eacc_r  <= '0;
      eneg_r  <= 1'b0;
      sign_r  <= 1'b0;
      rnd_r   <= 1'b0;
      err_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      dcnt_r  <= dcnt_nxt;
      pofs_r  <= pofs_nxt;
      eacc_r  <= eacc_nxt;
      eneg_r  <= eneg_nxt;
      sign_r  <= sign_nxt;
      rnd_r   <= rnd_nxt;
      err_r   <= err_nxt;
    end
  end

  // Payload and datapath registers carry no reset.
  always_ff @(posedge clk) begin
    m_r      <= m_nxt;
    tens_r   <= tens_nxt;
    e_r      <= e_nxt;
    low_r    <= low_nxt;
    carry_r  <= carry_nxt;
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
    neg_r    <= neg_nxt;
    bexp_r   <= bexp_nxt;
  end

  always_comb begin
    logic [7:0]           c;
    logic [3:0]           d;
    logic                 isd;
    logic                 do_asign, do_put, do_up, do_down, do_exp, do_after, do_clear;
    logic [15:0]          ev;
    logic [CW-1:0]        used;
    logic signed [EW-1:0] ex;
    logic signed [EW-2:0] eh;
    logic [3:0]           q, r;
    logic [6:0]           v, nv;
    logic                 wrap;

    state_nxt  = state_r;
    phase_nxt  = phase_r;
    m_nxt      = m_r;
    tens_nxt   = tens_r;
    dcnt_nxt   = dcnt_r;
    pofs_nxt   = pofs_r;
    eacc_nxt   = eacc_r;
    eneg_nxt   = eneg_r;
    sign_nxt   = sign_r;
    rnd_nxt    = rnd_r;
    err_nxt    = err_r;
    e_nxt      = e_r;
    low_nxt    = low_r;
    carry_nxt  = carry_r;
    idx_nxt    = idx_r;
    status_nxt = status_r;
    neg_nxt    = neg_r;
    bexp_nxt   = bexp_r;

    c   = in_bus.ch;
    d   = 4'(c - CH_ZERO);
    isd = (c >= CH_ZERO) && (c <= CH_NINE);
    do_asign = 1'b0;
    do_put   = 1'b0;
    do_up    = 1'b0;
    do_down  = 1'b0;
    do_exp   = 1'b0;
    do_after = 1'b0;
    do_clear = 1'b0;
    ev   = '0;
    used = '0;
    ex   = '0;
    eh   = '0;
    q    = div10(m_r[0]);
    r    = 4'(m_r[0] - 7'(q) * 7'd10);
    v    = m_r[MANTISSA_BYTES-1] + 7'(carry_r);
    wrap = (v == 7'd100);
    nv   = wrap ? 7'd0 : v;

    case (state_r)
      ST_PARSE: begin
        if (in_bus.valid) begin
          if (!in_bus.is_empty && !err_r) begin
            case (phase_r)
              PH_LEAD: begin
                if (c == CH_PLUS || c == CH_MINUS) begin
                  sign_nxt  = (c == CH_MINUS);
                  phase_nxt = PH_AFTERSIGN;
                end else if (c != CH_SPACE) begin
                  do_asign = 1'b1;
                end
              end
              PH_AFTERSIGN: do_asign = 1'b1;
              PH_DOT1: begin
                if (!isd) err_nxt = 1'b1;
                else if (c == CH_ZERO) begin
                  do_down = 1'b1; phase_nxt = PH_FZERO;
                end else begin
                  do_put = 1'b1; phase_nxt = PH_FRAC;
                end
              end
              PH_FZERO: begin
                if (c == CH_ZERO) do_down = 1'b1;
                else if (isd) begin
                  do_put = 1'b1; phase_nxt = PH_FRAC;
                end else do_after = 1'b1;
              end
              PH_FRAC: begin
                if (isd) do_put = 1'b1;
                else do_after = 1'b1;
              end
              PH_LZERO: begin
                if (c == CH_DOT) phase_nxt = PH_FZERO;
                else if (isd && c != CH_ZERO) begin
                  do_up = 1'b1; do_put = 1'b1; phase_nxt = PH_INT;
                end else if (!isd) err_nxt = 1'b1;
              end
              PH_INT: begin
                if (isd) begin
                  do_up = 1'b1; do_put = 1'b1;
                end else if (c == CH_DOT) phase_nxt = PH_FRAC;
                else do_after = 1'b1;
              end
              PH_EXP1: begin
                if (c == CH_PLUS || c == CH_MINUS) begin
                  eneg_nxt  = (c == CH_MINUS);
                  phase_nxt = PH_EXP2;
                end else if (isd) do_exp = 1'b1;
                else err_nxt = 1'b1;
              end
              PH_EXP2: begin
                if (isd) do_exp = 1'b1;
                else err_nxt = 1'b1;
              end
              PH_EXPD: begin
                if (isd) do_exp = 1'b1;
                else if (c == CH_SPACE) phase_nxt = PH_TRAIL;
                else err_nxt = 1'b1;
              end
              PH_TRAIL: begin
                if (c != CH_SPACE) err_nxt = 1'b1;
              end
              default: err_nxt = 1'b1;
            endcase

            if (do_asign) begin
              if (c == CH_DOT) phase_nxt = PH_DOT1;
              else if (!isd) err_nxt = 1'b1;
              else if (c == CH_ZERO) phase_nxt = PH_LZERO;
              else begin
                do_up = 1'b1; do_put = 1'b1; phase_nxt = PH_INT;
              end
            end
            if (do_after) begin
              if (c == CH_UE || c == CH_LE) phase_nxt = PH_EXP1;
              else if (c == CH_SPACE) phase_nxt = PH_TRAIL;
              else err_nxt = 1'b1;
            end
            if (do_up && pofs_r < PT_MAX) pofs_nxt = pofs_r + 16'sd1;
            if (do_down && pofs_r > PT_MIN) pofs_nxt = pofs_r - 16'sd1;
            if (do_exp) begin
              phase_nxt = PH_EXPD;
              if (eacc_r <= EXP_GROW_MAX) begin
                ev = 16'(eacc_r) * 16'd10 + 16'(d);
                eacc_nxt = (ev > 16'(EXP_SAT)) ? EXP_SAT : ev[14:0];
              end
            end
            // Pack the digit into its pair; count saturates one past full.
            if (do_put) begin
              if (dcnt_r < CW'(NDIG)) begin
                if (dcnt_r[0]) begin
                  m_nxt[IW'(dcnt_r >> 1)] = tens_r + 7'(d);
                end else begin
                  tens_nxt = 7'(d) * 7'd10;
                  m_nxt[IW'(dcnt_r >> 1)] = 7'(d) * 7'd10;
                end
                dcnt_nxt = dcnt_r + 1'b1;
              end else begin
                if (dcnt_r == CW'(NDIG) && d >= 4'd5) rnd_nxt = 1'b1;
                if (dcnt_r < CW'(NDIG + 1)) dcnt_nxt = dcnt_r + 1'b1;
              end
            end
          end
          if (in_bus.is_last) state_nxt = ST_LOAD;
        end
      end

      ST_LOAD: begin
        idx_nxt    = '0;
        low_nxt    = '0;
        carry_nxt  = 1'b1;
        status_nxt = STAT_OK;
        neg_nxt    = 1'b0;
        bexp_nxt   = '0;
        used = (dcnt_r + 1'b1) >> 1;
        for (int i = 0; i < MANTISSA_BYTES; i++) begin
          if (CW'(i) >= used) m_nxt[i] = '0;
        end
        ex = EW'(eacc_r);
        if (eneg_r) ex = -ex;
        e_nxt = ex + EW'(pofs_r);
        if (err_r || phase_r == PH_LEAD || phase_r == PH_AFTERSIGN ||
            phase_r == PH_DOT1 || phase_r == PH_EXP1 || phase_r == PH_EXP2) begin
          status_nxt = STAT_INVALID;
          state_nxt  = ST_FAIL;
        end else if (dcnt_r == '0) begin
          state_nxt = ST_EMIT;
        end else if (e_nxt[0]) begin
          state_nxt = ST_SHIFT;
        end else if (rnd_r) begin
          state_nxt = ST_ROUND;
        end else begin
          state_nxt = ST_EXPCHK;
        end
      end

      // Rotate left, moving each pair one decimal digit down.
      ST_SHIFT: begin
        for (int i = 0; i < MANTISSA_BYTES - 1; i++) m_nxt[i] = m_r[i+1];
        m_nxt[MANTISSA_BYTES-1] = 7'(low_r) * 7'd10 + 7'(q);
        low_nxt = r;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == IW'(MANTISSA_BYTES - 1)) begin
          idx_nxt   = '0;
          e_nxt     = e_r + EW'(1);
          carry_nxt = 1'b1;
          state_nxt = (r >= 4'd5) ? ST_ROUND : ST_EXPCHK;
        end
      end

      // Rotate right, adding the carry into the least significant pair.
      ST_ROUND: begin
        for (int i = 1; i < MANTISSA_BYTES; i++) m_nxt[i] = m_r[i-1];
        m_nxt[0]  = nv;
        carry_nxt = wrap;
        idx_nxt   = idx_r + 1'b1;
        if (idx_r == IW'(MANTISSA_BYTES - 1)) begin
          idx_nxt   = '0;
          state_nxt = ST_EXPCHK;
          if (wrap) begin
            m_nxt[0] = 7'd1;
            e_nxt    = e_r + EW'(2);
          end
        end
      end

      ST_EXPCHK: begin
        eh = e_r[EW-1:1];
        idx_nxt = '0;
        if (eh > 17'sd63) begin
          status_nxt = STAT_OVERFLOW;
          state_nxt  = ST_FAIL;
        end else if (eh < -17'sd63) begin
          for (int i = 0; i < MANTISSA_BYTES; i++) m_nxt[i] = '0;
          state_nxt = ST_EMIT;
        end else begin
          neg_nxt   = sign_r;
          bexp_nxt  = 7'(eh + 17'sd64);
          state_nxt = ST_EMIT;
        end
      end

      // Advance one pair per beat taken.
      ST_EMIT: begin
        if (out_bus.ready) begin
          for (int i = 0; i < MANTISSA_BYTES - 1; i++) m_nxt[i] = m_r[i+1];
          m_nxt[MANTISSA_BYTES-1] = '0;
          idx_nxt = idx_r + 1'b1;
          if (idx_r == IW'(MANTISSA_BYTES - 1)) do_clear = 1'b1;
        end
      end

      ST_FAIL: begin
        if (out_bus.ready) do_clear = 1'b1;
      end

      default: state_nxt = ST_PARSE;
    endcase

    if (do_clear) begin
      state_nxt = ST_PARSE;
      phase_nxt = PH_LEAD;
      dcnt_nxt  = '0;
      pofs_nxt  = '0;
      eacc_nxt  = '0;
      eneg_nxt  = 1'b0;
      sign_nxt  = 1'b0;
      rnd_nxt   = 1'b0;
      err_nxt   = 1'b0;
      idx_nxt   = '0;
    end
  end

  assign in_bus.ready            = (state_r == ST_PARSE);
  assign out_bus.valid           = (state_r == ST_EMIT) || (state_r == ST_FAIL);
  assign out_bus.status          = status_r;
  assign out_bus.negative        = (state_r == ST_FAIL) ? 1'b0 : neg_r;
  assign out_bus.biased_exponent = (state_r == ST_FAIL) ? 7'd0 : bexp_r;
  assign out_bus.digit_pos       = (state_r == ST_FAIL) ? '0 : DPW'(idx_r);
  assign out_bus.digit_value     = (state_r == ST_FAIL) ? 7'd0 : m_r[0];
  assign out_bus.last_digit      = (state_r == ST_FAIL) ||
                                   (idx_r == IW'(MANTISSA_BYTES - 1));

  // Input and output never overlap: the run is strictly sequential.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_bus.ready && out_bus.valid))
    else $error("input open while results pending");

  // Every emitted digit is a legal base-100 digit.
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid |-> out_bus.digit_value < 7'd100)
    else $error("digit out of range");

  // The final beat of a run reopens the input.
  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.ready && out_bus.last_digit |=> in_bus.ready)
    else $error("input not reopened after last beat");

  // A failure beat always carries a nonzero status.
  a_fail_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FAIL) |-> (status_r == STAT_INVALID || status_r == STAT_OVERFLOW))
    else $error("failure beat with ok status");

endmodule

// ===== test/tb_decimal_string_to_base100_float.sv =====
// Testbench for decimal_string_to_base100_float: drives numeric strings and checks digit beats.
// Depends on dsbf_pkg, dsbf_if.sv and the top level RTL.
`timescale 1ns / 1ps
module tb_decimal_string_to_base100_float;
  import dsbf_pkg::*;

  localparam int NB = MANTISSA_BYTES;

  typedef struct packed {
    logic [1:0] status;
    logic       negative;
    logic [6:0] bexp;
    logic [4:0] pos;
    logic [6:0] value;
    logic       last;
  } digit_beat_t;

  // Scoreboard: tracks the parser state of the string in flight and holds the
  // digit beats that the closing character of each string will produce.
  class float_scoreboard;
    logic [6:0] pairs[NB];
    int count, pt, ex;
    bit ex_neg, sgn, rnd, err;
    ph_t ph;
    digit_beat_t pending[$];
    int errors;

    function void clear_string();
      foreach (pairs[i]) pairs[i] = '0;
      count = 0; pt = 0; ex = 0;
      ex_neg = 0; sgn = 0; rnd = 0; err = 0;
      ph = PH_LEAD;
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function void add_digit(int d);
      if (count < 2 * NB) begin
        if (count % 2) pairs[count / 2] = 7'(pairs[count / 2] + d);
        else pairs[count / 2] = 7'(d * 10);
        count++;
      end else begin
        if (count == 2 * NB && d >= 5) rnd = 1;
        if (count < 2 * NB + 1) count++;
      end
    endfunction

    function void pt_up();
      if (pt < 32767) pt++;
    endfunction

    function void pt_down();
      if (pt > -32767) pt--;
    endfunction

    function void end_of_mantissa(logic [7:0] c);
      if (c == CH_UE || c == CH_LE) ph = PH_EXP1;
      else if (c == CH_SPACE) ph = PH_TRAIL;
      else err = 1;
    endfunction

    function void add_exp_digit(int d);
      int v;
      if (ex <= 3276) begin
        v = ex * 10 + d;
        ex = v > 32767 ? 32767 : v;
      end
      ph = PH_EXPD;
    endfunction

    function void first_char(logic [7:0] c);
      if (c == CH_DOT) ph = PH_DOT1;
      else if (!is_digit(c)) err = 1;
      else if (c == CH_ZERO) ph = PH_LZERO;
      else begin pt_up(); add_digit(c - CH_ZERO); ph = PH_INT; end
    endfunction

    function void parse_char(logic [7:0] c);
      case (ph)
        PH_LEAD: begin
          if (c == CH_PLUS || c == CH_MINUS) begin
            sgn = (c == CH_MINUS); ph = PH_AFTERSIGN;
          end else if (c != CH_SPACE) first_char(c);
        end
        PH_AFTERSIGN: first_char(c);
        PH_DOT1: begin
          if (!is_digit(c)) err = 1;
          else if (c == CH_ZERO) begin pt_down(); ph = PH_FZERO; end
          else begin add_digit(c - CH_ZERO); ph = PH_FRAC; end
        end
        PH_FZERO: begin
          if (c == CH_ZERO) pt_down();
          else if (is_digit(c)) begin add_digit(c - CH_ZERO); ph = PH_FRAC; end
          else end_of_mantissa(c);
        end
        PH_FRAC: begin
          if (is_digit(c)) add_digit(c - CH_ZERO);
          else end_of_mantissa(c);
        end
        PH_LZERO: begin
          if (c == CH_ZERO) ;
          else if (c == CH_DOT) ph = PH_FZERO;
          else if (is_digit(c)) begin pt_up(); add_digit(c - CH_ZERO); ph = PH_INT; end
          else err = 1;
        end
        PH_INT: begin
          if (is_digit(c)) begin pt_up(); add_digit(c - CH_ZERO); end
          else if (c == CH_DOT) ph = PH_FRAC;
          else end_of_mantissa(c);
        end
        PH_EXP1: begin
          if (c == CH_PLUS || c == CH_MINUS) begin
            ex_neg = (c == CH_MINUS); ph = PH_EXP2;
          end else if (is_digit(c)) add_exp_digit(c - CH_ZERO);
          else err = 1;
        end
        PH_EXP2: begin
          if (is_digit(c)) add_exp_digit(c - CH_ZERO);
          else err = 1;
        end
        PH_EXPD: begin
          if (is_digit(c)) add_exp_digit(c - CH_ZERO);
          else if (c == CH_SPACE) ph = PH_TRAIL;
          else err = 1;
        end
        PH_TRAIL: if (c != CH_SPACE) err = 1;
        default: err = 1;
      endcase
    endfunction

    function void push_fail(logic [1:0] st);
      digit_beat_t b;
      b = '0; b.status = st; b.last = 1;
      pending.push_back(b);
    endfunction

    // Normalize the held digits into base-100 beats.
    function void close_string();
      int m[NB];
      int e, used;
      bit neg, r;
      int bexp;
      digit_beat_t b;
      neg = 0; bexp = 0;
      foreach (m[i]) m[i] = 0;
      if (err || ph == PH_LEAD || ph == PH_AFTERSIGN || ph == PH_DOT1 ||
          ph == PH_EXP1 || ph == PH_EXP2) begin
        push_fail(STAT_INVALID);
        return;
      end
      if (count > 0) begin
        used = (count + 1) / 2;
        for (int i = 0; i < NB; i++) m[i] = (i < used) ? pairs[i] : 0;
        e = (ex_neg ? -ex : ex) + pt;
        r = rnd;
        if (e % 2 != 0) begin
          r = (m[NB-1] % 10) >= 5;
          for (int i = NB - 1; i > 0; i--) m[i] = (m[i-1] % 10) * 10 + m[i] / 10;
          m[0] = m[0] / 10;
          e += 1;
        end
        if (r) begin
          for (int i = NB - 1; i >= 0; i--) begin
            m[i]++;
            if (m[i] < 100) break;
            m[i] = 0;
          end
          if (m[0] == 0) begin
            for (int i = NB - 1; i > 0; i--) m[i] = m[i-1];
            m[0] = 1;
            e += 2;
          end
        end
        e = e / 2;
        if (e > 63) begin
          push_fail(STAT_OVERFLOW);
          return;
        end
        if (e < -63) foreach (m[i]) m[i] = 0;
        else begin neg = sgn; bexp = e + 64; end
      end
      for (int i = 0; i < NB; i++) begin
        b.status = STAT_OK; b.negative = neg; b.bexp = bexp[6:0];
        b.pos = i[4:0]; b.value = m[i][6:0]; b.last = (i == NB - 1);
        pending.push_back(b);
      end
    endfunction

    function void note_char(logic [7:0] c, bit is_last, bit is_empty);
      if (!is_empty && !err) parse_char(c);
      if (is_last) begin
        close_string();
        clear_string();
      end
    endfunction

    function void check_beat(digit_beat_t got);
      digit_beat_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status || got.negative !== want.negative ||
          got.bexp !== want.bexp || got.pos !== want.pos ||
          got.value !== want.value || got.last !== want.last) begin
        $display("%0t: mismatch expected st=%0d neg=%0d bexp=%0d pos=%0d val=%0d last=%0d",
                 $time, want.status, want.negative, want.bexp, want.pos, want.value,
                 want.last);
        $display("%0t:          actual   st=%0d neg=%0d bexp=%0d pos=%0d val=%0d last=%0d",
                 $time, got.status, got.negative, got.bexp, got.pos, got.value, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  always #2 clk = ~clk;

  dsbf_in_if  in_bus ();
  dsbf_out_if out_bus ();

  decimal_string_to_base100_float dut (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus.sink), .out_bus(out_bus.source)
  );

  float_scoreboard sb;
  bit calm;           // suppress idling on both sides during a stretch
  bit done_sending;
  int sent_beats;

  initial begin
    in_bus.valid = 0;
    in_bus.ch = 0;
    in_bus.is_last = 0;
    in_bus.is_empty = 0;
    out_bus.ready = 0;
  end

  // Send one character beat; hold it until taken, then maybe idle.
  task automatic send_char(logic [7:0] c, bit is_last, bit is_empty);
    in_bus.valid <= 1;
    in_bus.ch <= c;
    in_bus.is_last <= is_last;
    in_bus.is_empty <= is_empty;
    do @(posedge clk); while (!(in_bus.ready === 1'b1));
    sb.note_char(c, is_last, is_empty);
    sent_beats++;
    if (!calm) begin
      while ($urandom_range(99) < 24) begin
        in_bus.valid <= 0;
        @(posedge clk);
      end
    end
  endtask

  task automatic send_string(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1, 0);
  endtask

  function automatic string digits(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(8'(8'h30 + $urandom_range(9)))};
    return s;
  endfunction

  function automatic byte pick(string set);
    return set[$urandom_range(set.len() - 1)];
  endfunction

  // Build a mostly well-formed number with random content.
  function automatic string random_number();
    string s;
    s = "";
    repeat ($urandom_range(0, 2)) s = {s, " "};
    if ($urandom_range(1)) s = {s, string'(pick("+-"))};
    case ($urandom_range(3))
      0: s = {s, digits($urandom_range(1, 6))};
      1: s = {s, digits($urandom_range(0, 3)), ".", digits($urandom_range(1, 8))};
      2: s = {s, "000", digits($urandom_range(1, 45))};
      default: s = {s, ".", "0000", digits($urandom_range(0, 42))};
    endcase
    if ($urandom_range(2) == 0) begin
      s = {s, string'(pick("Ee"))};
      if ($urandom_range(1)) s = {s, string'(pick("+-"))};
      s = {s, digits($urandom_range(1, 3))};
    end
    repeat ($urandom_range(0, 1)) s = {s, " "};
    return s;
  endfunction

  // Receive side: random back-pressure, except during calm stretches.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1)
        sb.check_beat({out_bus.status, out_bus.negative, out_bus.biased_exponent,
                       out_bus.digit_pos, out_bus.digit_value, out_bus.last_digit});
      out_bus.ready <= calm || ($urandom_range(99) >= 24);
    end
  end

  initial begin
    string s;
    sb = new();
    sb.clear_string();
    calm = 0;
    done_sending = 0;
    sent_beats = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed strings: grammar corners, rounding, limits.
    send_string("0");
    send_string("-12.5");
    send_string("  +123.456E+3  ");
    send_string("1.5e-7");
    send_string(".000123");
    send_string({"9", digits(0), "999999999999999999999999999999999999999999"});
    send_string("99999999999999999999999999999999999999995");
    send_string("1E126");
    send_string("1E127");
    send_string("1E-127");
    send_string("1E-128");
    send_string("1e99999999");
    send_string("-1e-99999999");
    send_string("   ");
    send_string("-");
    send_string(".");
    send_string("1E");
    send_string("1E-");
    send_string("12a34");
    send_string("1 2");
    send_char(8'h00, 1, 1);
    send_char(8'hFF, 0, 1);
    send_char(8'hFF, 1, 0);
    send_string({"1", string'(8'h80), "5"});
    send_string("-00.000");

    // Random strings; a calm window in the middle.
    while (sent_beats < 380) begin
      calm = (sent_beats >= 240 && sent_beats < 300);
      if ($urandom_range(9) < 8) s = random_number();
      else begin
        s = "";
        repeat ($urandom_range(1, 6)) s = {s, string'(8'($urandom_range(255)))};
      end
      if (s.len() == 0) s = "5";
      for (int i = 0; i < s.len(); i++) begin
        if ($urandom_range(40) == 0) send_char(8'($urandom), 0, 1);
        send_char(s[i], i == s.len() - 1, 0);
      end
    end
    in_bus.valid <= 0;
    in_bus.is_last <= 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
